// ===== rtl/tbed_pkg.sv =====
`timescale 1ns / 1ps
// Package for the two-button event detector: item and result types,
// event bit positions and register reset value. No dependencies.
package tbed_pkg;

	localparam int unsigned EV_W     = 5;
	localparam int unsigned HOLD_W   = 16;

	localparam logic [HOLD_W-1:0] HOLD_TICKS_RESET = 16'd1464;

	localparam int unsigned EV_RIGHT_DOWN = 0;
	localparam int unsigned EV_RIGHT_UP   = 1;
	localparam int unsigned EV_LEFT_DOWN  = 2;
	localparam int unsigned EV_LEFT_UP    = 3;
	localparam int unsigned EV_BOTH_UP    = 4;

	typedef enum logic {
		KIND_TICK = 1'b0,
		KIND_READ = 1'b1
	} tbed_kind_t;

	typedef struct packed {
		tbed_kind_t kind;
		logic       right_pressed;
		logic       left_pressed;
	} tbed_item_t;

	typedef struct packed {
		logic [EV_W-1:0] events;
		logic            power_request;
	} tbed_result_t;

endpackage

// ===== rtl/tbed_core.sv =====
`timescale 1ns / 1ps
// Event state and hold counter of the two-button event detector.
// Updates state for one item when en is high; depends on tbed_pkg.
module tbed_core
	import tbed_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [HOLD_W-1:0]  cfg_data,
	input  logic               en,
	input  tbed_item_t         item,
	output tbed_result_t       res
);

	logic [HOLD_W-1:0] hold_ticks_q;
	logic              prev_right_q;
	logic              prev_left_q;
	logic              both_held_q;
	logic [HOLD_W-1:0] left_count_q;
	logic [EV_W-1:0]   pending_q;

	logic              prev_right_d;
	logic              prev_left_d;
	logic              both_held_d;
	logic [HOLD_W-1:0] left_count_d;
	logic [EV_W-1:0]   pending_d;
	logic [HOLD_W-1:0] count_inc;

	assign count_inc = left_count_q + 1'b1;

	always_comb begin
		logic r;
		logic l;
		r            = item.right_pressed;
		l            = item.left_pressed;
		prev_right_d = prev_right_q;
		prev_left_d  = prev_left_q;
		both_held_d  = both_held_q;
		left_count_d = left_count_q;
		pending_d    = pending_q;
		res          = '0;
		unique case (item.kind)
			KIND_READ: begin
				res.events = pending_q;
				pending_d  = '0;
			end
			KIND_TICK: begin
				if (!l) begin
					left_count_d = '0;
				end else if (left_count_q < hold_ticks_q) begin
					left_count_d      = count_inc;
					res.power_request = (count_inc == hold_ticks_q);
				end else begin
					left_count_d = hold_ticks_q;
				end

				if (r && l) begin
					both_held_d = 1'b1;
				end

				if (r && !prev_right_q) begin
					pending_d[EV_RIGHT_DOWN] = 1'b1;
				end else if (!r && prev_right_q) begin
					if (!both_held_d) begin
						pending_d[EV_RIGHT_UP] = 1'b1;
					end else if (!l) begin
						pending_d[EV_BOTH_UP] = 1'b1;
						both_held_d           = 1'b0;
					end
				end

				// left release sees both_held after the right release
				if (l && !prev_left_q) begin
					pending_d[EV_LEFT_DOWN] = 1'b1;
				end else if (!l && prev_left_q) begin
					if (!both_held_d) begin
						pending_d[EV_LEFT_UP] = 1'b1;
					end else if (!r) begin
						pending_d[EV_BOTH_UP] = 1'b1;
						both_held_d           = 1'b0;
					end
				end

				prev_right_d = r;
				prev_left_d  = l;
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks_q <= HOLD_TICKS_RESET;
		end else if (cfg_we) begin
			hold_ticks_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_right_q <= 1'b0;
			prev_left_q  <= 1'b0;
			both_held_q  <= 1'b0;
			left_count_q <= '0;
			pending_q    <= '0;
		end else if (en) begin
			prev_right_q <= prev_right_d;
			prev_left_q  <= prev_left_d;
			both_held_q  <= both_held_d;
			left_count_q <= left_count_d;
			pending_q    <= pending_d;
		end
	end

endmodule

// ===== rtl/two_button_event_detector.sv =====
`timescale 1ns / 1ps
// Top level of the two-button event detector: input register, result
// register and stream handshake around tbed_core; depends on tbed_pkg.
//
// Use: each input word is either a poll tick carrying both button levels
// (1 = pressed) or a read that returns and clears the pending event mask.
// Every input word gives exactly one output word. On a tick the output
// carries power_request, high on the tick the left hold count first
// reaches hold_ticks; on a read it carries the event mask.
// hold_ticks is written through cfg_we / cfg_data while the block is idle.
//
// Path: an accepted input word passes the input register, then one pass
// through the update logic into the result register, whose valid flag
// drives m_tvalid.
// Throughput: one word per cycle unless the output stalls; the state update
// is a single pass of flag logic and one 16-bit increment and compare.
// Reset: hold_ticks returns to 1464, all button state, the hold count and
// the event mask clear, and both registers are empty.
// Stall: while m_tready is low the result word holds; one more input word
// is taken into the input register, then s_tready drops until the output
// drains.
module two_button_event_detector
	import tbed_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [HOLD_W-1:0] cfg_data,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [0] right_pressed, [1] left_pressed, [7:2] zero
	input  logic [0:0]        s_tuser,   // [0] kind
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata    // [4:0] events, [5] power_request, [7:6] zero
);

	logic         valid_s1;
	tbed_item_t   item_s1;
	logic         m_tvalid_q;
	tbed_result_t result_q;
	tbed_result_t res;
	logic         advance;

	assign advance  = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.kind          <= tbed_kind_t'(s_tuser[0]);
			item_s1.right_pressed <= s_tdata[0];
			item_s1.left_pressed  <= s_tdata[1];
		end
	end

	tbed_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.en       (advance),
		.item     (item_s1),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, result_q.power_request, result_q.events};

	a_power_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[5]) |-> (m_tdata[4:0] == '0))
		else $error("power request together with events");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && m_tvalid_q && !m_tready))
		else $error("input stalled without a full pipeline");

	a_drain_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !m_tvalid_q) |=> m_tvalid_q)
		else $error("pending word not moved to output");

	a_read_no_power: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.kind == KIND_READ) |=> !m_tdata[5])
		else $error("power request on a read");

endmodule
